[design/md5_pkg.sv]
// MD5 package: item types, round constants, shift amounts and initial vector.
// No dependencies; used by every module of the MD5 block.
package md5_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       message_end;
    } t_in_item;

    typedef struct packed {
        logic [63:0] digest_first_half;
        logic [63:0] digest_second_half;
    } t_out_item;

    // Block handed from front to back: 16 words plus a flag for the final block
    typedef struct packed {
        logic [511:0] blk;
        logic         last;
    } t_blk_item;

    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hefcdab89;
    localparam logic [31:0] IV2 = 32'h98badcfe;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam logic [5:0]  LEN_POS  = 6'd56;

    function automatic logic [31:0] md5_k(input logic [5:0] i);
        logic [31:0] k;
        begin
            case (i)
                6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756; 6'd2: k = 32'h242070db;
                6'd3: k = 32'hc1bdceee; 6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
                6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501; 6'd8: k = 32'h698098d8;
                6'd9: k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
                6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
                6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
                6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
                6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
                6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
                6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
                6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
                6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
                6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
                6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
                6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
                6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
                6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
                6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
                6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
                6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
                6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
                default: k = 32'heb86d391;
            endcase
            return k;
        end
    endfunction

    function automatic logic [4:0] md5_s(input logic [3:0] j);
        logic [4:0] s;
        begin
            case (j)
                4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
                4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
                4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
                4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
            endcase
            return s;
        end
    endfunction

endpackage

[design/md5_if.sv]
// Valid/ready channel interface carrying one payload of a given type.
// The payload type is a parameter; this file does not itself import md5_pkg.
interface md5_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[design/md5_front.sv]
// Front part: packs bytes into a 64-byte block, keeps the bit count, pads.
// Depends on md5_pkg; feeds complete blocks to the block queue.
module md5_front import md5_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_in_item    i_item,
    output logic        o_ready,
    output logic        o_blk_valid,
    output t_blk_item   o_blk,
    input  logic        i_blk_ready
);
    typedef enum logic [3:0] {
        S_TAKE  = 4'b0001,
        S_PAD   = 4'b0010,
        S_EXTRA = 4'b0100,
        S_PUSH  = 4'b1000
    } t_state;

    t_state       r_state, n_state;
    logic [7:0]   r_buf [64];
    logic [63:0]  r_count;
    logic [63:0]  r_len;
    logic [5:0]   r_fill;
    logic         r_last;
    logic         r_end;
    logic [5:0]   w_pos;
    logic         w_acc;

    assign w_pos   = r_count[8:3];
    assign o_ready = (r_state == S_TAKE);
    assign w_acc   = i_valid && o_ready;
    assign o_blk_valid = (r_state == S_PUSH);

    // Present buffer as 16 little-endian words, word 0 in the low bits
    always_comb begin
        for (int k = 0; k < 64; k++) begin
            o_blk.blk[k*8 +: 8] = r_buf[k];
        end
        o_blk.last = r_last;
    end

    // Byte capture, zero fill and padding, one byte per cycle except while a block waits to be pushed
    always_ff @(posedge i_clk) begin
        if (w_acc && i_item.has_byte) begin
            r_buf[w_pos] <= i_item.data_byte;
        end
        if (r_state == S_PAD) begin
            if (r_fill == w_pos) begin
                r_buf[r_fill] <= PAD_BYTE;
            end else if (r_fill >= LEN_POS && r_fill > w_pos && !(w_pos >= LEN_POS)) begin
                r_buf[r_fill] <= r_len[(r_fill - LEN_POS)*8 +: 8];
            end else begin
                r_buf[r_fill] <= 8'h00;
            end
        end
        if (r_state == S_EXTRA) begin
            if (r_fill >= LEN_POS) begin
                r_buf[r_fill] <= r_len[(r_fill - LEN_POS)*8 +: 8];
            end else begin
                r_buf[r_fill] <= 8'h00;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_TAKE: begin
                if (w_acc && i_item.has_byte && w_pos == 6'd63) begin
                    n_state = S_PUSH;
                end else if (w_acc && i_item.message_end) begin
                    n_state = S_PAD;
                end
            end
            S_PAD:   if (r_fill == 6'd63) n_state = S_PUSH;
            S_EXTRA: if (r_fill == 6'd63) n_state = S_PUSH;
            S_PUSH: begin
                if (i_blk_ready) begin
                    if (r_last) n_state = S_TAKE;
                    else if (r_end) n_state = (w_pos >= LEN_POS) ? S_EXTRA : S_PAD;
                    else n_state = S_TAKE;
                end
            end
            default: n_state = S_TAKE;
        endcase
    end

    // Control: count, fill pointer, end and last flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_TAKE;
            r_count <= '0;
            r_fill  <= '0;
            r_last  <= 1'b0;
            r_end   <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_TAKE: begin
                    if (w_acc) begin
                        r_end <= i_item.message_end;
                        r_len <= r_count + (i_item.has_byte ? 64'd8 : 64'd0);
                        if (i_item.has_byte) r_count <= r_count + 64'd8;
                        r_fill <= r_count[8:3] + {5'd0, i_item.has_byte};
                        r_last <= 1'b0;
                    end
                end
                S_PAD: begin
                    r_fill <= r_fill + 6'd1;
                    if (r_fill == 6'd63) r_last <= (w_pos < LEN_POS);
                end
                S_EXTRA: begin
                    r_fill <= r_fill + 6'd1;
                    if (r_fill == 6'd63) r_last <= 1'b1;
                end
                S_PUSH: begin
                    if (i_blk_ready) begin
                        if (r_last) begin
                            r_count <= '0;
                            r_end   <= 1'b0;
                            r_last  <= 1'b0;
                        end else if (r_end) begin
                            r_fill <= (w_pos >= LEN_POS) ? 6'd0 : w_pos;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // The final block always carries the length, so it ends the message
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_blk_valid && o_blk.last) |-> r_end)
        else $error("last block without message end");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXTRA) |-> (w_pos >= LEN_POS))
        else $error("extra pad block with short tail");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_blk_valid && !i_blk_ready) |=> o_blk_valid)
        else $error("block dropped while stalled");
endmodule

[design/md5_queue.sv]
// Two-entry block queue between front and back parts.
// Depends on md5_pkg for the block type.
module md5_queue import md5_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_blk_item i_blk,
    output logic      o_ready,
    output logic      o_valid,
    output t_blk_item o_blk,
    input  logic      i_ready
);
    t_blk_item  r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_blk   = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= i_blk;
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt != 2'd3)
        else $error("queue overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) |-> (r_wp == r_rp))
        else $error("pointers disagree when empty");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> (r_wp == r_rp))
        else $error("pointers disagree when full");
endmodule

[design/md5_back.sv]
// Back part: 64-round compression, one round per cycle, chaining update.
// Depends on md5_pkg; emits the digest after the final block.
module md5_back import md5_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_blk_item i_blk,
    output logic      o_ready,
    output logic      o_valid,
    output t_out_item o_item,
    input  logic      i_ready
);
    logic [31:0] r_h [4];
    logic [31:0] r_a, r_b, r_c, r_d;
    logic [511:0] r_m;
    logic        r_last;
    logic        r_busy;
    logic        r_fin;
    logic [5:0]  r_i;
    logic        r_ov;
    t_out_item   r_out;
    logic [31:0] w_f, w_t, w_rot, w_m;
    logic [3:0]  w_g;
    logic [1:0]  w_r;
    logic [4:0]  w_s;
    logic [63:0] w_h0, w_h1;

    assign o_ready = !r_busy && !r_fin;
    assign o_valid = r_ov;
    assign o_item  = r_out;
    assign w_r     = r_i[5:4];

    // One round of the compression
    always_comb begin
        case (w_r)
            2'd0: begin w_f = (r_b & r_c) | (~r_b & r_d); w_g = r_i[3:0]; end
            2'd1: begin w_f = (r_b & r_d) | (r_c & ~r_d); w_g = r_i[3:0]*4'd5 + 4'd1; end
            2'd2: begin w_f = r_b ^ r_c ^ r_d; w_g = r_i[3:0]*4'd3 + 4'd5; end
            default: begin w_f = r_c ^ (r_b | ~r_d); w_g = r_i[3:0]*4'd7; end
        endcase
        w_m   = r_m[w_g*32 +: 32];
        w_s   = md5_s({w_r, r_i[1:0]});
        w_t   = r_a + w_f + md5_k(r_i) + w_m;
        w_rot = (w_t << w_s) | (w_t >> (6'd32 - {1'b0, w_s}));
    end

    // Digest bytes, low byte of each word first
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_h0[63 - 8*k -: 8] = r_h[0][8*k +: 8];
            w_h0[31 - 8*k -: 8] = r_h[1][8*k +: 8];
            w_h1[63 - 8*k -: 8] = r_h[2][8*k +: 8];
            w_h1[31 - 8*k -: 8] = r_h[3][8*k +: 8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_m <= i_blk.blk;
            r_last <= i_blk.last;
        end
        if (r_fin && !(r_ov && !i_ready)) r_out <= '{w_h0, w_h1};
    end

    // Round sequencing, chaining add and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h[0] <= IV0; r_h[1] <= IV1; r_h[2] <= IV2; r_h[3] <= IV3;
            r_busy <= 1'b0; r_fin <= 1'b0; r_ov <= 1'b0; r_i <= '0;
        end else begin
            if (r_ov && i_ready && !r_fin) r_ov <= 1'b0;
            if (i_valid && o_ready) begin
                r_busy <= 1'b1; r_i <= '0;
                r_a <= r_h[0]; r_b <= r_h[1]; r_c <= r_h[2]; r_d <= r_h[3];
            end else if (r_busy) begin
                r_a <= r_d; r_d <= r_c; r_c <= r_b; r_b <= r_b + w_rot;
                r_i <= r_i + 6'd1;
                if (r_i == 6'd63) begin
                    r_busy <= 1'b0;
                    r_h[0] <= r_h[0] + r_d;
                    r_h[1] <= r_h[1] + r_b + w_rot;
                    r_h[2] <= r_h[2] + r_b;
                    r_h[3] <= r_h[3] + r_c;
                    r_fin  <= r_last;
                end
            end else if (r_fin && !(r_ov && !i_ready)) begin
                r_ov  <= 1'b1;
                r_fin <= 1'b0;
                r_h[0] <= IV0; r_h[1] <= IV1; r_h[2] <= IV2; r_h[3] <= IV3;
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) !(r_busy && r_fin))
        else $error("finish flagged mid-block");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_i == 6'd63) |=> !r_busy)
        else $error("round counter overran");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ov) |-> (r_h[0] == IV0))
        else $error("chaining not reloaded after digest");
endmodule

[design/md5_message_digest.sv]
// Top level of the MD5 digest block: front, block queue, compression back.
// Depends on md5_pkg, md5_if, md5_front, md5_queue and md5_back.
//
//   channel   dir  payload
//   in_ch     in   data_byte[7:0], has_byte, message_end
//   out_ch    out  digest_first_half[63:0], digest_second_half[63:0]
//
// Bytes are taken one per cycle while a block fills; after the 64th byte the
// input is held while the block moves into a two-entry queue. Compression
// runs 64 rounds a block after a load, one round per cycle on a single
// round unit. A message end holds the input while the front pads, and a
// further block is padded when the tail leaves no room for the length. The
// digest is registered via the finish flag, then the output register. Reset is
// synchronous and clears all control state; either side may stall without loss.
module md5_message_digest import md5_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    md5_if.sink   in_ch,
    md5_if.source out_ch
);
    logic      w_fv, w_fr, w_qv, w_qr;
    t_blk_item w_fb, w_qb;

    md5_front u_front (
        .i_clk, .i_rst_n,
        .i_valid(in_ch.valid), .i_item(in_ch.data), .o_ready(in_ch.ready),
        .o_blk_valid(w_fv), .o_blk(w_fb), .i_blk_ready(w_fr)
    );

    md5_queue u_queue (
        .i_clk, .i_rst_n,
        .i_valid(w_fv), .i_blk(w_fb), .o_ready(w_fr),
        .o_valid(w_qv), .o_blk(w_qb), .i_ready(w_qr)
    );

    md5_back u_back (
        .i_clk, .i_rst_n,
        .i_valid(w_qv), .i_blk(w_qb), .o_ready(w_qr),
        .o_valid(out_ch.valid), .o_item(out_ch.data), .i_ready(out_ch.ready)
    );
endmodule
